>>> hw/rtl/bpa_pkg.sv
// shared types, codes and helper functions of the buddy page allocator
package bpa_pkg;

    // default sizing
    localparam int DEF_POOL_PAGES = 32768;
    localparam int DEF_MAX_BLOCKS = 64;

    // largest block in pages
    localparam logic [16:0] SIZE_CAP = 17'd32768;

    // request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // one free table entry
    typedef struct packed {
        logic        valid;
        logic [14:0] base;
        logic [15:0] size;
    } entry_t;

    // highest set bit of v, as a value
    function automatic logic [15:0] msb_val(input logic [15:0] v);
        logic [15:0] r;
        r = 16'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (v[i])
            begin
                r = 16'd1 << i;
            end
        end
        return r;
    endfunction

    // index of the highest set bit of v
    function automatic logic [4:0] log2_idx(input logic [16:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (v[i])
            begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    // smallest power of two not below c, zero taken as one
    function automatic logic [16:0] round_pow2(input logic [15:0] c);
        logic [15:0] d;
        logic [16:0] r;
        d = c - 16'd1;
        r = 17'd1;
        if (c > 16'd1)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (d[i])
                begin
                    r = 17'd2 << i;
                end
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/bpa_cell.sv
// one free table cell of the rotating entry ring
module bpa_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  bpa_pkg::entry_t d,
    output bpa_pkg::entry_t q
);
    import bpa_pkg::*;

    logic        valid_reg;
    logic [14:0] base_reg;
    logic [15:0] size_reg;

    // valid flag, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= d.base;
            size_reg <= d.size;
        end
    end

    assign q = '{valid: valid_reg, base: base_reg, size: size_reg};

endmodule

>>> hw/rtl/buddy_page_allocator.sv
// buddy page allocator top level: entry ring and request sequencer
//
// Requests enter on start when busy is low: req_type selects allocate or
// free, page_count is rounded up to a power of two, base_page names the
// block being freed. Each request gives one result, shown for one cycle
// with done high: status, block_base, block_pages and free_total. The
// receiver cannot stall; results are simply presented.
// The free table is a ring of MAX_BLOCKS cells that rotates, while busy,
// by one entry a cycle past the sequencer, which reads and rewrites the
// head cell. One pass takes the ring once round. An allocate takes two
// passes; one that fails ends after the first pass. A free takes one pass
// per merge search, up to two per merge level and at most 30 passes, then
// an insert pass. Writing pool_pages on the cfg channel (accepted while
// idle) rebuilds the table in one pass; after reset the same rebuild of a
// POOL_PAGES pool, capped at 32768 pages, runs with busy high before the
// first request.
module buddy_page_allocator #(
    parameter int POOL_PAGES = bpa_pkg::DEF_POOL_PAGES,
    parameter int MAX_BLOCKS = bpa_pkg::DEF_MAX_BLOCKS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [15:0] page_count,
    input  logic [14:0] base_page,
    output logic        done,
    output logic [1:0]  status,
    output logic [14:0] block_base,
    output logic [15:0] block_pages,
    output logic [15:0] free_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import bpa_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS);
    localparam int EW = $clog2(MAX_BLOCKS + 1);
    localparam int CAP_PAGES = (POOL_PAGES < 32768) ? POOL_PAGES : 32768;
    localparam logic [16:0] CAP_W = 17'(CAP_PAGES);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_REBUILD = 7'b0000010,
        S_AFIND   = 7'b0000100,
        S_ASPLIT  = 7'b0001000,
        S_FLOWER  = 7'b0010000,
        S_FUPPER  = 7'b0100000,
        S_FINSERT = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [15:0]     top_reg, top_next;
    logic [15:0]     pf_reg, pf_next;
    logic [16:0]     n_reg, n_next;
    logic [14:0]     cb_reg, cb_next;
    logic [15:0]     cs_reg, cs_next;
    logic            found_reg, found_next;
    logic            ok_reg, ok_next;
    logic [15:0]     bs_reg, bs_next;
    logic [14:0]     bb_reg, bb_next;
    logic [EW-1:0]   empt_reg, empt_next;
    logic            flag_reg, flag_next;
    logic            up_reg, up_next;
    logic [15:0]     h_reg, h_next;
    logic [14:0]     lb_reg, lb_next;
    logic            done_reg, done_next;
    logic [1:0]      st_reg, st_next;
    logic [14:0]     ob_reg, ob_next;
    logic [15:0]     op_reg, op_next;

    entry_t ring_q [MAX_BLOCKS];
    entry_t ring_d [MAX_BLOCKS];
    entry_t head, head_new;
    logic   shift;
    logic   last;

    // rotating ring of cells, head at cell zero
    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            if (g == MAX_BLOCKS - 1)
            begin : g_tail
                assign ring_d[g] = head_new;
            end
            else
            begin : g_mid
                assign ring_d[g] = ring_q[g+1];
            end
            bpa_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (shift),
                .d     (ring_d[g]),
                .q     (ring_q[g])
            );
        end
    endgenerate

    assign head  = ring_q[0];
    assign shift = (state_reg != S_IDLE);
    assign last  = (cnt_reg == CW'(MAX_BLOCKS - 1));

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = (state_reg == S_IDLE) && !start;
    assign done        = done_reg;
    assign status      = st_reg;
    assign block_base  = ob_reg;
    assign block_pages = op_reg;
    assign free_total  = pf_reg;

    // sequencer
    always_comb
    begin
        logic [16:0] rn;
        logic [16:0] nf;
        logic [15:0] s;
        logic [15:0] hh;
        logic        pending;
        logic        mlow;
        logic        mup;
        logic        msel;
        logic [4:0]  need;
        logic [15:0] cs2;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        pf_next    = pf_reg;
        n_next     = n_reg;
        cb_next    = cb_reg;
        cs_next    = cs_reg;
        found_next = found_reg;
        ok_next    = ok_reg;
        bs_next    = bs_reg;
        bb_next    = bb_reg;
        empt_next  = empt_reg;
        flag_next  = flag_reg;
        up_next    = up_reg;
        h_next     = h_reg;
        lb_next    = lb_reg;
        done_next  = 1'b0;
        st_next    = st_reg;
        ob_next    = ob_reg;
        op_next    = op_reg;
        head_new   = head;

        rn      = round_pow2(page_count);
        nf      = (rn > SIZE_CAP) ? SIZE_CAP : rn;
        s       = msb_val(top_reg);
        hh      = h_reg >> 1;
        pending = ({1'b0, h_reg} > n_reg);
        mlow    = head.valid && (head.size == cs_reg) &&
                  (({2'b0, head.base} + {1'b0, cs_reg}) == {2'b0, cb_reg});
        mup     = head.valid && (head.size == cs_reg) &&
                  (({2'b0, cb_reg} + {1'b0, cs_reg}) == {2'b0, head.base});
        msel    = head.valid && (head.size == bs_reg) && (head.base == bb_reg);
        need    = 5'd0;
        cs2     = cs_reg << 1;

        if (shift)
        begin
            cnt_next = last ? '0 : cnt_reg + CW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    flag_next = 1'b0;
                    up_next   = 1'b0;
                    if (req_type == REQ_ALLOC)
                    begin
                        n_next     = rn;
                        ok_next    = (rn <= SIZE_CAP) && (rn <= {1'b0, pf_reg});
                        found_next = 1'b0;
                        empt_next  = '0;
                        state_next = S_AFIND;
                    end
                    else
                    begin
                        n_next     = nf;
                        cb_next    = base_page;
                        cs_next    = nf[15:0];
                        state_next = (nf >= SIZE_CAP) ? S_FINSERT : S_FLOWER;
                    end
                end
                else if (cfg_valid)
                begin
                    top_next   = ({1'b0, cfg_data} > CAP_W) ? CAP_W[15:0] : cfg_data;
                    pf_next    = 16'd0;
                    state_next = S_REBUILD;
                end
            end

            // top-down decomposition, one block per cell
            S_REBUILD:
            begin
                if (top_reg != 16'd0)
                begin
                    head_new = '{valid: 1'b1, base: 15'(top_reg - s), size: s};
                    top_next = top_reg - s;
                    pf_next  = pf_reg + s;
                end
                else
                begin
                    head_new.valid = 1'b0;
                end
                if (last)
                begin
                    state_next = S_IDLE;
                end
            end

            // smallest fitting block at the lowest base, count empty cells
            S_AFIND:
            begin
                if (ok_reg && head.valid && ({1'b0, head.size} >= n_reg) &&
                    (!found_reg || (head.size < bs_reg) ||
                     ((head.size == bs_reg) && (head.base < bb_reg))))
                begin
                    found_next = 1'b1;
                    bs_next    = head.size;
                    bb_next    = head.base;
                end
                if (!head.valid)
                begin
                    empt_next = empt_reg + EW'(1);
                end
                if (last)
                begin
                    // halvings from the chosen block down to the request size
                    need = log2_idx({1'b0, bs_next}) - log2_idx(n_reg);
                    if (!found_next)
                    begin
                        done_next  = 1'b1;
                        st_next    = ST_NO_BLOCK;
                        ob_next    = 15'd0;
                        op_next    = 16'd0;
                        state_next = S_IDLE;
                    end
                    else if ((32'(empt_next) + 32'd1) < 32'(need))
                    begin
                        done_next  = 1'b1;
                        st_next    = ST_FULL;
                        ob_next    = 15'd0;
                        op_next    = 16'd0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        h_next     = bs_next;
                        flag_next  = 1'b0;
                        state_next = S_ASPLIT;
                    end
                end
            end

            // take the chosen block out, drop the upper halves into free cells
            S_ASPLIT:
            begin
                if (!flag_reg && msel)
                begin
                    flag_next = 1'b1;
                    if (pending)
                    begin
                        head_new = '{valid: 1'b1, base: bb_reg + hh[14:0], size: hh};
                        h_next   = hh;
                    end
                    else
                    begin
                        head_new.valid = 1'b0;
                    end
                end
                else if (!head.valid && pending)
                begin
                    head_new = '{valid: 1'b1, base: bb_reg + hh[14:0], size: hh};
                    h_next   = hh;
                end
                if (last)
                begin
                    done_next  = 1'b1;
                    st_next    = ST_OK;
                    ob_next    = bb_reg;
                    op_next    = n_reg[15:0];
                    pf_next    = pf_reg - n_reg[15:0];
                    state_next = S_IDLE;
                end
            end

            // merge with the lower buddy, note an upper one
            S_FLOWER:
            begin
                if (mlow && !flag_reg)
                begin
                    head_new.valid = 1'b0;
                    flag_next      = 1'b1;
                    lb_next        = head.base;
                end
                if (mup)
                begin
                    up_next = 1'b1;
                end
                if (last)
                begin
                    if (flag_next)
                    begin
                        cb_next    = lb_next;
                        cs_next    = cs2;
                        state_next = ({1'b0, cs2} >= SIZE_CAP) ? S_FINSERT : S_FLOWER;
                    end
                    else if (up_next)
                    begin
                        state_next = S_FUPPER;
                    end
                    else
                    begin
                        state_next = S_FINSERT;
                    end
                    flag_next = 1'b0;
                    up_next   = 1'b0;
                end
            end

            // merge with the upper buddy
            S_FUPPER:
            begin
                if (mup && !flag_reg)
                begin
                    head_new.valid = 1'b0;
                    flag_next      = 1'b1;
                end
                if (last)
                begin
                    flag_next  = 1'b0;
                    up_next    = 1'b0;
                    cs_next    = cs2;
                    state_next = ({1'b0, cs2} >= SIZE_CAP) ? S_FINSERT : S_FLOWER;
                end
            end

            // place the merged block in the first free cell
            S_FINSERT:
            begin
                if (!head.valid && !flag_reg)
                begin
                    head_new  = '{valid: 1'b1, base: cb_reg, size: cs_reg};
                    flag_next = 1'b1;
                end
                if (last)
                begin
                    done_next  = 1'b1;
                    st_next    = flag_next ? ST_OK : ST_FULL;
                    ob_next    = 15'd0;
                    op_next    = n_reg[15:0];
                    pf_next    = flag_next ? pf_reg + n_reg[15:0] : pf_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_REBUILD;
            cnt_reg   <= '0;
            top_reg   <= CAP_W[15:0];
            pf_reg    <= 16'd0;
            found_reg <= 1'b0;
            ok_reg    <= 1'b0;
            empt_reg  <= '0;
            flag_reg  <= 1'b0;
            up_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
            pf_reg    <= pf_next;
            found_reg <= found_next;
            ok_reg    <= ok_next;
            empt_reg  <= empt_next;
            flag_reg  <= flag_next;
            up_reg    <= up_next;
            done_reg  <= done_next;
        end
    end

    // request payload and result registers
    always_ff @(posedge clk)
    begin
        n_reg  <= n_next;
        cb_reg <= cb_next;
        cs_reg <= cs_next;
        bs_reg <= bs_next;
        bb_reg <= bb_next;
        h_reg  <= h_next;
        lb_reg <= lb_next;
        st_reg <= st_next;
        ob_reg <= ob_next;
        op_reg <= op_next;
    end

endmodule

>>> verif/tb_top.sv
// self-checking testbench of the buddy page allocator with its own free table predictor
module tb_top;
    import bpa_pkg::*;

    localparam int TABLE_SLOTS = 64;
    localparam int LARGEST = 32768;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [1:0]  status;
        logic [14:0] base;
        logic [15:0] pages;
        logic [15:0] total;
    } outcome_t;

    // queue of predicted outcomes, checked in request order
    class alloc_scoreboard;
        outcome_t pending[$];
        int errors = 0;

        function void note(outcome_t e);
            pending.push_back(e);
        endfunction

        function void compare(string what, int e, int a);
            if (e != a)
            begin
                errors++;
                $display("%0t %s mismatch: expected %0d actual %0d", $time, what, e, a);
            end
        endfunction

        function void check(outcome_t a);
            outcome_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual status %0d base %0d",
                         $time, a.status, a.base);
                return;
            end
            e = pending.pop_front();
            compare("status", e.status, a.status);
            compare("block_base", e.base, a.base);
            compare("block_pages", e.pages, a.pages);
            compare("free_total", e.total, a.total);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [15:0] page_count;
    logic [14:0] base_page;
    logic        done;
    logic [1:0]  status;
    logic [14:0] block_base;
    logic [15:0] block_pages;
    logic [15:0] free_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    alloc_scoreboard sb;

    // predicted free table
    bit          blk_used[TABLE_SLOTS];
    int          blk_base[TABLE_SLOTS];
    int          blk_size[TABLE_SLOTS];
    logic [15:0] pages_left;

    // blocks handed out, for well-formed frees
    int held_base[$];
    int held_size[$];

    int idle_pct;
    int quiet_cycles;

    buddy_page_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .page_count(page_count), .base_page(base_page),
        .done(done), .status(status), .block_base(block_base),
        .block_pages(block_pages), .free_total(free_total),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int first_hole();
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (!blk_used[i])
            begin
                return i;
            end
        end
        return TABLE_SLOTS;
    endfunction

    function automatic int hole_count();
        int c;
        c = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (!blk_used[i])
            begin
                c++;
            end
        end
        return c;
    endfunction

    function automatic void place(int slot, int b, int s);
        blk_used[slot] = 1'b1;
        blk_base[slot] = b & 16'h7fff;
        blk_size[slot] = s & 16'hffff;
    endfunction

    // top-down decomposition of the pool
    function automatic void rebuild_table(logic [15:0] pool);
        int top;
        int s;
        int slot;
        top = (pool > LARGEST) ? LARGEST : pool;
        pages_left = 16'd0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            blk_used[i] = 1'b0;
            blk_base[i] = 0;
            blk_size[i] = 0;
        end
        while (top > 0)
        begin
            s = 1;
            while ((s << 1) <= top)
            begin
                s <<= 1;
            end
            top -= s;
            slot = first_hole();
            if (slot < TABLE_SLOTS)
            begin
                place(slot, top, s);
                pages_left += 16'(s);
            end
        end
    endfunction

    function automatic int pow2_ceil(logic [15:0] c);
        int p;
        p = 1;
        while (p < c)
        begin
            p <<= 1;
        end
        return p;
    endfunction

    // expected outcome of one request, updating the predicted table
    function automatic outcome_t predict_request(logic kind, logic [15:0] cnt, logic [14:0] fb);
        outcome_t r;
        int n;
        int best;
        int b;
        int s;
        int need;
        int h;
        int cb;
        int cs;
        int slot;
        bit merged;
        r.status = ST_OK;
        r.base = 15'd0;
        r.pages = 16'd0;
        n = pow2_ceil(cnt);
        if (kind == REQ_ALLOC)
        begin
            best = TABLE_SLOTS;
            if (n <= LARGEST && n <= pages_left)
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (!blk_used[i] || blk_size[i] < n)
                    begin
                        continue;
                    end
                    if (best == TABLE_SLOTS || blk_size[i] < blk_size[best] ||
                        (blk_size[i] == blk_size[best] && blk_base[i] < blk_base[best]))
                    begin
                        best = i;
                    end
                end
            end
            if (best == TABLE_SLOTS)
            begin
                r.status = ST_NO_BLOCK;
            end
            else
            begin
                b = blk_base[best];
                s = blk_size[best];
                need = 0;
                for (h = s; h > n; h >>= 1)
                begin
                    need++;
                end
                blk_used[best] = 1'b0;
                if (hole_count() < need)
                begin
                    blk_used[best] = 1'b1;
                    r.status = ST_FULL;
                end
                else
                begin
                    h = s;
                    while (h > n)
                    begin
                        h >>= 1;
                        place(first_hole(), b + h, h);
                    end
                    pages_left -= 16'(n);
                    r.base = 15'(b);
                    r.pages = 16'(n);
                end
            end
        end
        else
        begin
            if (n > LARGEST)
            begin
                n = LARGEST;
            end
            cb = fb;
            cs = n;
            r.pages = 16'(n);
            merged = 1'b1;
            // lower neighbour first, then upper, until nothing merges
            while (merged && cs < LARGEST)
            begin
                merged = 1'b0;
                for (int i = 0; i < TABLE_SLOTS && !merged; i++)
                begin
                    if (blk_used[i] && blk_size[i] == cs && blk_base[i] + cs == cb)
                    begin
                        blk_used[i] = 1'b0;
                        cb = blk_base[i];
                        cs <<= 1;
                        merged = 1'b1;
                    end
                end
                for (int i = 0; i < TABLE_SLOTS && !merged; i++)
                begin
                    if (blk_used[i] && blk_size[i] == cs && cb + cs == blk_base[i])
                    begin
                        blk_used[i] = 1'b0;
                        cs <<= 1;
                        merged = 1'b1;
                    end
                end
            end
            slot = first_hole();
            if (slot == TABLE_SLOTS)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                place(slot, cb, cs);
                pages_left += 16'(n);
            end
        end
        r.total = pages_left;
        return r;
    endfunction

    // issue one request and wait until it is taken
    task automatic send_request(logic kind, logic [15:0] cnt, logic [14:0] fb);
        outcome_t e;
        start = 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
        end
        start = 1'b1;
        req_type = kind;
        page_count = cnt;
        base_page = fb;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        e = predict_request(kind, cnt, fb);
        sb.note(e);
        if (kind == REQ_ALLOC && e.status == ST_OK)
        begin
            held_base.push_back(e.base);
            held_size.push_back(e.pages);
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    // write the pool size once every outstanding request has finished
    task automatic write_pool(logic [15:0] pool);
        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
        cfg_valid = 1'b1;
        cfg_data = pool;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        rebuild_table(pool);
        held_base.delete();
        held_size.delete();
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data = 16'($urandom);
    endtask

    // free a previously granted block
    task automatic free_held();
        int k;
        int b;
        int s;
        k = $urandom_range(held_base.size() - 1);
        b = held_base[k];
        s = held_size[k];
        held_base.delete(k);
        held_size.delete(k);
        send_request(REQ_FREE, 16'(s), 15'(b));
    endtask

    // mostly small counts, now and then a large one
    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 70)
        begin
            return 16'($urandom_range(0, 64));
        end
        else if (r < 95)
        begin
            return 16'($urandom_range(0, 4096));
        end
        return 16'($urandom);
    endfunction

    // result monitor
    always @(posedge clk)
    begin
        outcome_t a;
        if (rst_n && done)
        begin
            a.status = status;
            a.base = block_base;
            a.pages = block_pages;
            a.total = free_total;
            sb.check(a);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int pools[6];
        int r;
        sb = new();
        quiet_cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_ALLOC;
        page_count = 16'd0;
        base_page = 15'd0;
        cfg_valid = 1'b0;
        cfg_data = 16'd0;
        rebuild_table(16'd32768);
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: zero and oversized counts, both-sided merges, merge limit
        send_request(REQ_ALLOC, 16'd1, 15'd0);
        send_request(REQ_ALLOC, 16'd0, 15'h7fff);
        send_request(REQ_ALLOC, 16'd1, 15'd0);
        send_request(REQ_ALLOC, 16'd32768, 15'd0);
        send_request(REQ_ALLOC, 16'hffff, 15'd0);
        send_request(REQ_FREE, 16'd0, 15'd1);
        send_request(REQ_FREE, 16'd1, 15'd0);
        send_request(REQ_FREE, 16'd1, 15'd2);
        send_request(REQ_ALLOC, 16'd32768, 15'd0);
        send_request(REQ_ALLOC, 16'd1, 15'd0);
        send_request(REQ_FREE, 16'hffff, 15'd0);
        send_request(REQ_ALLOC, 16'd3, 15'd0);
        send_request(REQ_ALLOC, 16'd16385, 15'd0);
        write_pool(16'd1);
        send_request(REQ_ALLOC, 16'd2, 15'd0);
        send_request(REQ_ALLOC, 16'd1, 15'd0);
        send_request(REQ_FREE, 16'd1, 15'd0);
        write_pool(16'hffff);
        send_request(REQ_ALLOC, 16'd32768, 15'd0);
        write_pool(16'h7fff);
        send_request(REQ_ALLOC, 16'd5, 15'd0);

        // table overflow on split and on free, starting from an empty pool
        write_pool(16'd0);
        send_request(REQ_ALLOC, 16'd1, 15'd0);
        for (int i = 0; i < 63; i++)
        begin
            send_request(REQ_FREE, 16'd2, 15'(i * 4));
        end
        send_request(REQ_FREE, 16'd64, 15'd8192);
        send_request(REQ_ALLOC, 16'd4, 15'd0);
        send_request(REQ_FREE, 16'd1, 15'd20000);
        send_request(REQ_ALLOC, 16'd2, 15'd0);
        send_request(REQ_FREE, 16'd1, 15'd20000);

        // random phases with varying pool sizes and sender gaps
        pools = '{32768, 1, 65535, 0, 12345, 32767};
        for (int ph = 0; ph < 11; ph++)
        begin
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 82 : 27);
            write_pool((ph < 6) ? 16'(pools[ph]) : 16'($urandom));
            for (int j = 0; j < 100; j++)
            begin
                r = $urandom_range(99);
                if (r < 55)
                begin
                    send_request(REQ_ALLOC, pick_count(), 15'($urandom));
                end
                else if (r < 88 && held_base.size() != 0)
                begin
                    free_held();
                end
                else
                begin
                    send_request(REQ_FREE, pick_count(), 15'($urandom));
                end
            end
        end

        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
